/* sv/vzt_pkg.sv */
package vzt_pkg;

   typedef struct packed {
      logic [31:0] price;
      logic [31:0] volume;
      logic [31:0] forecast_price;
      logic        forecast_valid;
   } req_type;

   typedef struct packed {
      logic signed [15:0] z_score;
      logic               model_agrees;
      logic               trade_fire;
      logic               resized;
      logic [31:0]        fill_qty;
   } rsp_type;

   localparam logic OP_DIV  = 1'b0;
   localparam logic OP_SQRT = 1'b1;

   typedef struct packed {
      logic        start;
      logic        op;
      logic [63:0] a_hi;
      logic [63:0] a_lo;
      logic [63:0] den;
   } unit_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } unit_rsp_type;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_Z_THRESHOLD  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP_TICKS = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_NOTIONAL = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER_QTY    = 8'd3;

   localparam logic [15:0] RST_Z_THRESHOLD  = 16'hFE00;
   localparam logic [15:0] RST_WARMUP_TICKS = 16'd30;
   localparam logic [47:0] RST_MAX_NOTIONAL = 48'd15000000;
   localparam logic [31:0] RST_ORDER_QTY    = 32'd163840;

endpackage

/* sv/vzt_iter_unit.sv */
module vzt_iter_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  vzt_pkg::unit_req_type unit_req,
   output vzt_pkg::unit_rsp_type unit_rsp
);
   import vzt_pkg::*;

   localparam int CNT_W = 7;
   localparam logic [CNT_W-1:0] DIV_STEPS  = 7'd64;
   localparam logic [CNT_W-1:0] SQRT_STEPS = 7'd32;

   logic [63:0]      rem_ff, rem_in, aux_ff, aux_in, quo_ff, quo_in, den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in, op_ff, op_in;
   logic [64:0]      x, y, diff;
   logic             take;

   always_comb begin
      if (op_ff == OP_SQRT) begin
         x = {1'b0, rem_ff};
         y = {1'b0, quo_ff + aux_ff};
      end else begin
         x = {rem_ff, aux_ff[63]};
         y = {1'b0, den_ff};
      end
      diff = x - y;
      take = (x >= y);
   end

   always_comb begin
      rem_in  = rem_ff;
      aux_in  = aux_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      op_in   = op_ff;
      done_in = 1'b0;
      if (unit_req.start) begin
         op_in  = unit_req.op;
         den_in = unit_req.den;
         quo_in = '0;
         if (unit_req.op == OP_SQRT) begin
            rem_in  = unit_req.a_lo;
            aux_in  = 64'h4000_0000_0000_0000;
            cnt_in  = SQRT_STEPS;
            busy_in = 1'b1;
         end else if (unit_req.a_hi >= unit_req.den) begin
            quo_in  = '1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = unit_req.a_hi;
            aux_in  = unit_req.a_lo;
            cnt_in  = DIV_STEPS;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (op_ff == OP_SQRT) begin
            rem_in = take ? diff[63:0] : rem_ff;
            quo_in = take ? ((quo_ff >> 1) + aux_ff) : (quo_ff >> 1);
            aux_in = aux_ff >> 2;
         end else begin
            rem_in = take ? diff[63:0] : x[63:0];
            quo_in = {quo_ff[62:0], take};
            aux_in = aux_ff << 1;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      aux_ff <= aux_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign unit_rsp.done   = done_ff;
   assign unit_rsp.result = quo_ff;

endmodule

/* sv/vwap_zscore_trade_gate_top.sv */
// Channel | Direction | Ports                          | Beat
// req     | in        | req_valid, req_stall, req_data | one market tick
// rsp     | out       | rsp_valid, rsp_stall, rsp_data | one scored tick
// csr     | in        | csr_we, csr_index, csr_wdata   | one register write
// A tick holds the block from its accept cycle through the rsp load, and how long
// it stays is set by the shared divide and root unit, which runs one to five divides
// and at most one root for each tick. Ticks that skip the VWAP, variance, z or cap
// division finish sooner.
// Reset is synchronous and clears all statistics and restores register defaults.
// req_stall is high while a tick is being worked; a waiting rsp beat does not
// block the next tick from being accepted.
module vwap_zscore_trade_gate_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  vzt_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output vzt_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [vzt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vzt_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import vzt_pkg::*;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_PV   = 5'd1;
   localparam logic [4:0] S_ACC  = 5'd2;
   localparam logic [4:0] S_W1   = 5'd3;
   localparam logic [4:0] S_WAIT = 5'd4;
   localparam logic [4:0] S_W2   = 5'd5;
   localparam logic [4:0] S_W3   = 5'd6;
   localparam logic [4:0] S_MM   = 5'd7;
   localparam logic [4:0] S_M2   = 5'd8;
   localparam logic [4:0] S_VW   = 5'd9;
   localparam logic [4:0] S_VW2  = 5'd10;
   localparam logic [4:0] S_VAR  = 5'd11;
   localparam logic [4:0] S_SQ   = 5'd12;
   localparam logic [4:0] S_SQ2  = 5'd13;
   localparam logic [4:0] S_ZS   = 5'd14;
   localparam logic [4:0] S_Z2   = 5'd15;
   localparam logic [4:0] S_DEC  = 5'd16;
   localparam logic [4:0] S_CAP  = 5'd17;
   localparam logic [4:0] S_CAP2 = 5'd18;
   localparam logic [4:0] S_DONE = 5'd19;

   logic [4:0]  state_ff, state_in, ret_ff, ret_in;
   req_type     tick_ff, tick_in;
   logic [63:0] cum_value_ff, cum_value_in, cum_volume_ff, cum_volume_in;
   logic [31:0] tick_total_ff, tick_total_in;
   logic [47:0] mean_ff, mean_in, m1_ff, m1_in, m2_ff, m2_in, vwap_ff, vwap_in;
   logic [63:0] sum_sq_ff, sum_sq_in, prod_ff, prod_in;
   logic [95:0] acc_ff, acc_in;
   logic [2:0]  mm_cnt_ff, mm_cnt_in;
   logic        neg1_ff, neg1_in, negd_ff, negd_in;
   logic [31:0] s_ff, s_in, qty_ff, qty_in;
   logic [15:0] z_ff, z_in;
   logic        agree_ff, agree_in, fire_ff, fire_in, cut_ff, cut_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [15:0] thr_ff, thr_in, warm_ff, warm_in;
   logic [47:0] notional_ff, notional_in;
   logic [31:0] oqty_ff, oqty_in;

   logic [31:0]  mul_a, mul_b;
   logic [47:0]  pq, dd;
   logic [64:0]  sum65;
   logic [63:0]  cap;
   unit_req_type unit_req;
   unit_rsp_type unit_rsp;

   vzt_iter_unit u_unit (
      .clock    (clock),
      .reset    (reset),
      .unit_req (unit_req),
      .unit_rsp (unit_rsp)
   );

   assign pq  = {tick_ff.price, 16'h0000};
   assign cap = {notional_ff, 16'h0000};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_PV: begin
            mul_a = tick_ff.price;
            mul_b = tick_ff.volume;
         end
         S_DEC: begin
            mul_a = tick_ff.price;
            mul_b = oqty_ff;
         end
         S_MM: begin
            case (mm_cnt_ff)
               3'd0: begin
                  mul_a = m1_ff[31:0];
                  mul_b = m2_ff[31:0];
               end
               3'd1: begin
                  mul_a = m1_ff[31:0];
                  mul_b = {16'h0000, m2_ff[47:32]};
               end
               3'd2: begin
                  mul_a = {16'h0000, m1_ff[47:32]};
                  mul_b = m2_ff[31:0];
               end
               3'd3: begin
                  mul_a = {16'h0000, m1_ff[47:32]};
                  mul_b = {16'h0000, m2_ff[47:32]};
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      tick_in       = tick_ff;
      cum_value_in  = cum_value_ff;
      cum_volume_in = cum_volume_ff;
      tick_total_in = tick_total_ff;
      mean_in       = mean_ff;
      m1_in         = m1_ff;
      m2_in         = m2_ff;
      vwap_in       = vwap_ff;
      sum_sq_in     = sum_sq_ff;
      acc_in        = acc_ff;
      mm_cnt_in     = mm_cnt_ff;
      neg1_in       = neg1_ff;
      negd_in       = negd_ff;
      s_in          = s_ff;
      qty_in        = qty_ff;
      z_in          = z_ff;
      agree_in      = agree_ff;
      fire_in       = fire_ff;
      cut_in        = cut_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      thr_in        = thr_ff;
      warm_in       = warm_ff;
      notional_in   = notional_ff;
      oqty_in       = oqty_ff;
      unit_req      = '0;
      sum65         = '0;
      dd            = '0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_Z_THRESHOLD:  thr_in      = csr_wdata[15:0];
            CSR_WARMUP_TICKS: warm_in     = csr_wdata[15:0];
            CSR_MAX_NOTIONAL: notional_in = csr_wdata;
            CSR_ORDER_QTY:    oqty_in     = csr_wdata[31:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               tick_in  = req_data;
               state_in = S_PV;
            end
         end
         S_PV: state_in = S_ACC;
         S_ACC: begin
            sum65        = {1'b0, cum_value_ff} + {1'b0, prod_ff};
            cum_value_in = sum65[64] ? '1 : sum65[63:0];
            sum65        = {1'b0, cum_volume_ff} + {33'h0, tick_ff.volume};
            cum_volume_in = sum65[64] ? '1 : sum65[63:0];
            if (tick_total_ff != '1) begin
               tick_total_in = tick_total_ff + 1'b1;
            end
            state_in = S_W1;
         end
         S_W1: begin
            neg1_in       = pq < mean_ff;
            dd            = neg1_in ? (mean_ff - pq) : (pq - mean_ff);
            m1_in         = dd;
            unit_req.start = 1'b1;
            unit_req.op    = OP_DIV;
            unit_req.a_lo  = {16'h0000, dd};
            unit_req.den   = {32'h0, tick_total_ff};
            ret_in        = S_W2;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (unit_rsp.done) begin
               state_in = ret_ff;
            end
         end
         S_W2: begin
            mean_in  = neg1_ff ? (mean_ff - unit_rsp.result[47:0])
                               : (mean_ff + unit_rsp.result[47:0]);
            state_in = S_W3;
         end
         S_W3: begin
            m2_in     = (pq < mean_ff) ? (mean_ff - pq) : (pq - mean_ff);
            mm_cnt_in = '0;
            state_in  = S_MM;
         end
         S_MM: begin
            case (mm_cnt_ff) inside
               3'd0: acc_in = '0;
               3'd1: acc_in = acc_ff + {32'h0, prod_ff};
               3'd2, 3'd3: acc_in = acc_ff + {prod_ff, 32'h0};
               default: acc_in = acc_ff + {prod_ff[31:0], 64'h0};
            endcase
            mm_cnt_in = mm_cnt_ff + 1'b1;
            if (mm_cnt_ff == 3'd4) begin
               state_in = S_M2;
            end
         end
         S_M2: begin
            sum65 = {1'b0, sum_sq_ff} + {1'b0, acc_ff[79:16]};
            if (acc_ff[95:80] != '0 || sum65[64]) begin
               sum_sq_in = '1;
            end else begin
               sum_sq_in = sum65[63:0];
            end
            state_in = S_VW;
         end
         S_VW: begin
            if (cum_volume_ff == '0) begin
               vwap_in  = pq;
               state_in = S_VAR;
            end else begin
               unit_req.start = 1'b1;
               unit_req.op    = OP_DIV;
               unit_req.a_hi  = {48'h0, cum_value_ff[63:48]};
               unit_req.a_lo  = {cum_value_ff[47:0], 16'h0000};
               unit_req.den   = cum_volume_ff;
               ret_in         = S_VW2;
               state_in       = S_WAIT;
            end
         end
         S_VW2: begin
            vwap_in  = (unit_rsp.result[63:48] != '0) ? '1 : unit_rsp.result[47:0];
            state_in = S_VAR;
         end
         S_VAR: begin
            if (tick_total_ff > 32'd1) begin
               unit_req.start = 1'b1;
               unit_req.op    = OP_DIV;
               unit_req.a_lo  = sum_sq_ff;
               unit_req.den   = {32'h0, tick_total_ff - 1'b1};
               ret_in         = S_SQ;
               state_in       = S_WAIT;
            end else begin
               s_in     = '0;
               state_in = S_ZS;
            end
         end
         S_SQ: begin
            unit_req.start = 1'b1;
            unit_req.op    = OP_SQRT;
            unit_req.a_lo  = unit_rsp.result;
            ret_in         = S_SQ2;
            state_in       = S_WAIT;
         end
         S_SQ2: begin
            s_in     = unit_rsp.result[31:0];
            state_in = S_ZS;
         end
         S_ZS: begin
            if (s_ff == '0) begin
               z_in     = '0;
               state_in = S_DEC;
            end else begin
               negd_in        = pq < vwap_ff;
               dd             = negd_in ? (vwap_ff - pq) : (pq - vwap_ff);
               unit_req.start = 1'b1;
               unit_req.op    = OP_DIV;
               unit_req.a_lo  = {16'h0000, dd};
               unit_req.den   = {32'h0, s_ff};
               ret_in         = S_Z2;
               state_in       = S_WAIT;
            end
         end
         S_Z2: begin
            if (negd_ff) begin
               z_in = (unit_rsp.result > 64'd32768) ? 16'h8000
                                                    : (16'h0000 - unit_rsp.result[15:0]);
            end else begin
               z_in = (unit_rsp.result > 64'd32767) ? 16'h7FFF : unit_rsp.result[15:0];
            end
            state_in = S_DEC;
         end
         S_DEC: begin
            agree_in = tick_ff.forecast_valid && (tick_ff.forecast_price > tick_ff.price);
            fire_in  = (tick_total_ff > {16'h0, warm_ff}) &&
                       ($signed(z_ff) <= $signed(thr_ff)) && agree_in;
            state_in = S_CAP;
         end
         S_CAP: begin
            if (fire_ff && (prod_ff > cap) && (tick_ff.price != '0)) begin
               unit_req.start = 1'b1;
               unit_req.op    = OP_DIV;
               unit_req.a_lo  = cap;
               unit_req.den   = {32'h0, tick_ff.price};
               ret_in         = S_CAP2;
               state_in       = S_WAIT;
            end else begin
               qty_in   = fire_ff ? oqty_ff : '0;
               cut_in   = 1'b0;
               state_in = S_DONE;
            end
         end
         S_CAP2: begin
            qty_in   = unit_rsp.result[31:0];
            cut_in   = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.z_score      = z_ff;
               rsp_data_in.model_agrees = agree_ff;
               rsp_data_in.trade_fire   = fire_ff;
               rsp_data_in.resized      = cut_ff;
               rsp_data_in.fill_qty     = qty_ff;
               state_in                 = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      tick_ff     <= tick_in;
      m1_ff       <= m1_in;
      m2_ff       <= m2_in;
      vwap_ff     <= vwap_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      mm_cnt_ff   <= mm_cnt_in;
      neg1_ff     <= neg1_in;
      negd_ff     <= negd_in;
      s_ff        <= s_in;
      qty_ff      <= qty_in;
      z_ff        <= z_in;
      agree_ff    <= agree_in;
      fire_ff     <= fire_in;
      cut_ff      <= cut_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         cum_value_ff  <= '0;
         cum_volume_ff <= '0;
         tick_total_ff <= '0;
         mean_ff       <= '0;
         sum_sq_ff     <= '0;
         thr_ff        <= RST_Z_THRESHOLD;
         warm_ff       <= RST_WARMUP_TICKS;
         notional_ff   <= RST_MAX_NOTIONAL;
         oqty_ff       <= RST_ORDER_QTY;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         cum_value_ff  <= cum_value_in;
         cum_volume_ff <= cum_volume_in;
         tick_total_ff <= tick_total_in;
         mean_ff       <= mean_in;
         sum_sq_ff     <= sum_sq_in;
         thr_ff        <= thr_in;
         warm_ff       <= warm_in;
         notional_ff   <= notional_in;
         oqty_ff       <= oqty_in;
      end
   end

   assign req_stall = reset || (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* sv/vzt_checker.sv */
module vzt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input vzt_pkg::rsp_type               rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req not stalled after a beat was accepted");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_no_fire_no_qty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.trade_fire |-> rsp_data.fill_qty == '0 && !rsp_data.resized)
      else $error("quantity reported without a trade");

   a_fire_needs_agree: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.trade_fire |-> rsp_data.model_agrees)
      else $error("trade fired without forecast agreement");

endmodule

bind vwap_zscore_trade_gate_top vzt_checker u_vzt_checker (.*);

/* tb/sv/tb_vwap_zscore_trade_gate_top.sv */
module tb_vwap_zscore_trade_gate_top;
   import vzt_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   vwap_zscore_trade_gate_top dut (.*);

   always #10 clock = ~clock;

   logic signed [15:0] thr_reg;
   logic [15:0] warm_reg;
   logic [47:0] cap_reg;
   logic [31:0] qty_reg;
   logic [63:0] acc_value, acc_volume, sq_dev;
   logic [31:0] ticks_seen;
   logic [47:0] run_mean;

   rsp_type scored_q[$];
   int errors = 0;
   int idle_count = 0;
   int stall_left = 0;
   int beats_in = 0;
   int beats_out = 0;
   int fires_seen = 0;
   int resizes_seen = 0;
   bit calm = 1'b0;

   function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] bitv;
      r = '0;
      bitv = 64'h1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v = v - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   function automatic void restore_defaults();
      thr_reg = RST_Z_THRESHOLD;
      warm_reg = RST_WARMUP_TICKS;
      cap_reg = RST_MAX_NOTIONAL;
      qty_reg = RST_ORDER_QTY;
      acc_value = '0;
      acc_volume = '0;
      sq_dev = '0;
      ticks_seen = '0;
      run_mean = '0;
   endfunction

   function automatic rsp_type score_tick(req_type t);
      rsp_type r;
      logic [63:0] pq, vwap, n, m1, m2, s, mag, q, cap;
      logic [127:0] num, prod;
      logic negd, agree;
      logic signed [17:0] z;
      pq = {16'd0, t.price, 16'd0};
      acc_value = sat_sum(acc_value, 64'(t.price) * 64'(t.volume));
      acc_volume = sat_sum(acc_volume, 64'(t.volume));
      if (acc_volume == 0) begin
         vwap = pq;
      end else begin
         num = {48'd0, acc_value, 16'd0};
         num = num / acc_volume;
         vwap = (num > 128'hFFFFFFFFFFFF) ? 64'hFFFFFFFFFFFF : num[63:0];
      end
      if (ticks_seen != '1) ticks_seen = ticks_seen + 32'd1;
      n = 64'(ticks_seen);
      if (pq < run_mean) begin
         m1 = 64'(run_mean) - pq;
         run_mean = run_mean - 48'(m1 / n);
      end else begin
         m1 = pq - 64'(run_mean);
         run_mean = run_mean + 48'(m1 / n);
      end
      m2 = (pq < run_mean) ? 64'(run_mean) - pq : pq - 64'(run_mean);
      prod = 128'(m1) * 128'(m2);
      if (prod[127:80] != 0) sq_dev = '1;
      else sq_dev = sat_sum(sq_dev, prod[79:16]);
      s = (n > 1) ? floor_root(sq_dev / (n - 1)) : 64'd0;
      if (s == 0) begin
         z = '0;
      end else begin
         negd = pq < vwap;
         mag = negd ? vwap - pq : pq - vwap;
         q = mag / s;
         if (negd) z = (q > 32768) ? -18'sd32768 : -$signed({1'b0, q[16:0]});
         else z = (q > 32767) ? 18'sd32767 : $signed({1'b0, q[16:0]});
      end
      agree = t.forecast_valid && (t.forecast_price > t.price);
      r = '0;
      r.z_score = z[15:0];
      r.model_agrees = agree;
      if (n > 64'(warm_reg) && z <= 18'(thr_reg) && agree) begin
         cap = {cap_reg, 16'd0};
         r.trade_fire = 1'b1;
         r.fill_qty = qty_reg;
         if (64'(t.price) * 64'(qty_reg) > cap && t.price != 0) begin
            r.fill_qty = 32'(cap / 64'(t.price));
            r.resized = 1'b1;
         end
      end
      return r;
   endfunction

   task automatic idle_burst();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic send_tick(req_type t);
      idle_burst();
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (req_stall);
      scored_q.push_back(score_tick(t));
      beats_in++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (scored_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_Z_THRESHOLD:  thr_reg = val[15:0];
         CSR_WARMUP_TICKS: warm_reg = val[15:0];
         CSR_MAX_NOTIONAL: cap_reg = val;
         CSR_ORDER_QTY:    qty_reg = val[31:0];
         default: ;
      endcase
   endtask

   function automatic req_type near_tick(logic [31:0] base);
      req_type t;
      t.price = base + $urandom_range(0, 200) - 100;
      t.volume = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0010_0000);
      t.forecast_price = t.price + $urandom_range(0, 60) - 20;
      t.forecast_valid = $urandom_range(0, 4) != 0;
      return t;
   endfunction

   function automatic req_type noise_tick();
      req_type t;
      t.price = $urandom();
      t.volume = $urandom();
      t.forecast_price = $urandom();
      t.forecast_valid = 1'($urandom_range(0, 1));
      return t;
   endfunction

   task automatic test_extremes();
      req_type t;
      t = '{price: 0, volume: 0, forecast_price: 0, forecast_valid: 0};
      send_tick(t);
      t = '{price: '1, volume: '1, forecast_price: '1, forecast_valid: 1};
      send_tick(t);
      t = '{price: 1, volume: 0, forecast_price: 2, forecast_valid: 1};
      send_tick(t);
      t = '{price: '1, volume: '1, forecast_price: 0, forecast_valid: 1};
      repeat (4) send_tick(t);
      t = '{price: 5, volume: 1, forecast_price: '1, forecast_valid: 0};
      send_tick(t);
      wait_drained();
   endtask

   task automatic test_trade_gate();
      req_type t;
      write_reg(CSR_WARMUP_TICKS, 48'd0);
      write_reg(CSR_Z_THRESHOLD, 48'h7FFF);
      write_reg(CSR_ORDER_QTY, 48'hFFFF_FFFF);
      write_reg(CSR_MAX_NOTIONAL, 48'hFFFF_FFFF_FFFF);
      for (int i = 0; i < 8; i++) send_tick(near_tick(32'd100000));
      t = '{price: 32'd100000, volume: 32'h10000, forecast_price: 32'd100001,
            forecast_valid: 1};
      send_tick(t);
      wait_drained();
      write_reg(CSR_MAX_NOTIONAL, 48'd0);
      write_reg(CSR_Z_THRESHOLD, 48'h8000);
      for (int i = 0; i < 8; i++) send_tick(near_tick(32'd100000));
      wait_drained();
      write_reg(CSR_WARMUP_TICKS, 48'hFFFF);
      write_reg(CSR_ORDER_QTY, 48'd0);
      write_reg(8'd9, 48'h1234);
      for (int i = 0; i < 4; i++) send_tick(near_tick(32'd100000));
      wait_drained();
   endtask

   task automatic test_random_phase(logic [15:0] thr, logic [15:0] warm, logic [47:0] cap,
                                    logic [31:0] qty, int count);
      logic [31:0] base;
      write_reg(CSR_Z_THRESHOLD, 48'(thr));
      write_reg(CSR_WARMUP_TICKS, 48'(warm));
      write_reg(CSR_MAX_NOTIONAL, cap);
      write_reg(CSR_ORDER_QTY, 48'(qty));
      base = $urandom_range(1000, 32'h00FF_FFFF);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) send_tick(noise_tick());
         else send_tick(near_tick(base));
         if ($urandom_range(0, 29) == 0) base = base + $urandom_range(0, 2000) - 1000;
      end
      wait_drained();
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            beats_out++;
            if (scored_q.size() == 0) begin
               $error("unexpected rsp beat %p", rsp_data);
               errors++;
            end else begin
               want = scored_q.pop_front();
               if (want.trade_fire) fires_seen++;
               if (want.resized) resizes_seen++;
               if (rsp_data.z_score !== want.z_score) begin
                  $error("z_score exp %0d got %0d", want.z_score, rsp_data.z_score);
                  errors++;
               end
               if (rsp_data.model_agrees !== want.model_agrees) begin
                  $error("model_agrees exp %0d got %0d", want.model_agrees,
                         rsp_data.model_agrees);
                  errors++;
               end
               if (rsp_data.trade_fire !== want.trade_fire) begin
                  $error("trade_fire exp %0d got %0d", want.trade_fire, rsp_data.trade_fire);
                  errors++;
               end
               if (rsp_data.resized !== want.resized) begin
                  $error("resized exp %0d got %0d", want.resized, rsp_data.resized);
                  errors++;
               end
               if (rsp_data.fill_qty !== want.fill_qty) begin
                  $error("fill_qty exp %0d got %0d", want.fill_qty,
                         rsp_data.fill_qty);
                  errors++;
               end
            end
         end
         if (calm) begin
            rsp_stall <= 1'b0;
            stall_left <= 0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(0, 4);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      restore_defaults();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_trade_gate();
      test_random_phase(16'hFE00, 16'd30, 48'd15000000, 32'd163840, 400);
      test_random_phase(16'h0000, 16'd0, 48'd1, 32'h0002_8000, 300);
      test_random_phase(16'h7FFF, 16'd5, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 300);
      test_random_phase(16'h8000, 16'd100, 48'd50000, 32'h0001_0000, 250);
      calm = 1'b1;
      test_random_phase(16'h0100, 16'd10, 48'd3000000, 32'h0003_0000, 300);
      $display("covered %0d ticks, %0d scored beats, %0d trades, %0d resized",
               beats_in, beats_out, fires_seen, resizes_seen);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* vwap_zscore_trade_gate_top.f */
sv/vzt_pkg.sv
sv/vzt_iter_unit.sv
sv/vwap_zscore_trade_gate_top.sv
sv/vzt_checker.sv
tb/sv/tb_vwap_zscore_trade_gate_top.sv
